FILE: src/complete_elliptic_integrals_agm_assert.svh
// Assertion macros used by the checker file.
`ifndef COMPLETE_ELLIPTIC_INTEGRALS_AGM_ASSERT_SVH
`define COMPLETE_ELLIPTIC_INTEGRALS_AGM_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define CEAGM_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define CEAGM_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

FILE: src/ceagm_pkg.sv
`timescale 1ns / 1ps
package ceagm_pkg;

    localparam int DEF_MAX_ITERATIONS     = 16;
    localparam int DEF_WORK_FRACTION_BITS = 40;

    // pi/2 in Q2.62
    localparam logic [63:0] HALF_PI_Q62 = 64'h6487_ED51_10B4_611A;
    // 1.0 in signed Q4.28
    localparam logic signed [31:0] M_ONE_Q28 = 32'sh1000_0000;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_K_INF   = 2'd1,
        ST_NO_CONV = 2'd2,
        ST_M_ABOVE = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        OP_MUL  = 2'd0,
        OP_DIV  = 2'd1,
        OP_SQRT = 2'd2
    } unit_op_t;

    typedef struct packed {
        logic     start;
        unit_op_t op;
    } unit_req_t;

    typedef struct packed {
        logic busy;
        logic done;
    } unit_stat_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DIV_D,
        S_SQRT_B,
        S_STEP,
        S_MUL_AB,
        S_SQRT_AB,
        S_MUL_CC,
        S_DIV_K,
        S_MUL_E,
        S_SQRT_R,
        S_DIV_KN,
        S_MUL_EN,
        S_FIN
    } state_t;

endpackage

FILE: src/complete_elliptic_integrals_agm.sv
`timescale 1ns / 1ps
// Channel  Handshake             Payload
// in       in_valid / in_stall   parameter_m (s Q4.28)
// out      out_valid / out_stall k_value, e_value (u Q8.24), status
//
// One beat in, one beat out. m = 1 and m > 1 go straight to S_FIN. Otherwise the shared
// unit runs a square root, per AGM step a multiply, square root and multiply, then a divide
// and a multiply; negative m adds a divide before and a square root, divide and multiply
// after. Square root and divide run at one bit a cycle, multiply by 32x32 partials.
// in_stall is high from acceptance until the result is in the output register, which
// holds under out_stall while a new beat is taken. Reset clears control only.
module complete_elliptic_integrals_agm #(
    parameter int MAX_ITERATIONS     = ceagm_pkg::DEF_MAX_ITERATIONS,
    parameter int WORK_FRACTION_BITS = ceagm_pkg::DEF_WORK_FRACTION_BITS
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [31:0] parameter_m,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] k_value,
    output logic [31:0] e_value,
    output logic [1:0]  status
);
    import ceagm_pkg::*;

    localparam int F  = WORK_FRACTION_BITS;
    localparam int IW = (MAX_ITERATIONS > 1) ? $clog2(MAX_ITERATIONS) : 1;
    localparam logic [63:0] ONE = 64'd1 << F;
    // numerator of K = pi/2 * 2^(2F) / a
    localparam int KSHL = (2 * F >= 62) ? 2 * F - 62 : 0;
    localparam int KSHR = (2 * F >= 62) ? 0 : 62 - 2 * F;
    localparam logic [127:0] KNUM = ({64'd0, HALF_PI_Q62} << KSHL) >> KSHR;

    function automatic logic [63:0] sat64(input logic [127:0] v);
        return (v[127:64] != 64'd0) ? {64{1'b1}} : v[63:0];
    endfunction

    function automatic logic [31:0] to_q24(input logic [63:0] v);
        logic [63:0] r;
        r = v >> (F - 24);
        return (r[63:32] != 32'd0) ? {32{1'b1}} : r[31:0];
    endfunction

    state_t state_reg, state_next;

    logic          neg_reg, neg_next;
    logic [32:0]   w_reg, w_next;          // 2^28 - m for negative m
    logic [63:0]   a_reg, a_next;
    logic [63:0]   b_reg, b_next;
    logic [63:0]   s_reg, s_next;
    logic [63:0]   c_reg, c_next;
    logic [63:0]   t_reg, t_next;
    logic [63:0]   kw_reg, kw_next;
    logic [63:0]   ew_reg, ew_next;
    logic [63:0]   r_reg, r_next;
    logic [IW-1:0] i_reg, i_next;
    logic [31:0]   kq_reg, kq_next;
    logic [31:0]   eq_reg, eq_next;
    status_t       st_reg, st_next;

    logic          out_valid_reg, out_valid_next;
    logic [31:0]   k_out_reg, k_out_next;
    logic [31:0]   e_out_reg, e_out_next;
    status_t       st_out_reg, st_out_next;

    unit_req_t     ureq;
    unit_stat_t    ustat;
    logic [127:0]  uopa, ures;
    logic [63:0]   uopb;

    logic signed [31:0] m_in;
    logic [32:0]   mneg;
    logic [63:0]   d_in, d_div, ew_tmp;
    logic [127:0]  p_term;
    logic [63:0]   term;
    logic [64:0]   s_sum, ab_sum;

    ceagm_unit u_unit (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (ureq),
        .opa   (uopa),
        .opb   (uopb),
        .stat  (ustat),
        .res   (ures)
    );

    always_comb
    begin
        m_in   = $signed(parameter_m);
        mneg   = 33'd0 - {parameter_m[31], parameter_m};
        d_in   = 64'(parameter_m) << (F - 28);
        d_div  = (ures[63:0] > ONE) ? ONE : ures[63:0];
        ab_sum = {1'b0, a_reg} + {1'b0, b_reg};
        // c*c * 2^i / 2^F
        if (int'(i_reg) <= F)
            p_term = ures >> (F - int'(i_reg));
        else
            p_term = ures << (int'(i_reg) - F);
        term   = sat64(p_term);
        s_sum  = {1'b0, s_reg} + {1'b0, term};
        ew_tmp = sat64(ures >> F);

        state_next = state_reg;
        neg_next   = neg_reg;
        w_next     = w_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        s_next     = s_reg;
        c_next     = c_reg;
        t_next     = t_reg;
        kw_next    = kw_reg;
        ew_next    = ew_reg;
        r_next     = r_reg;
        i_next     = i_reg;
        kq_next    = kq_reg;
        eq_next    = eq_reg;
        st_next    = st_reg;

        out_valid_next = out_valid_reg & out_stall;
        k_out_next     = k_out_reg;
        e_out_next     = e_out_reg;
        st_out_next    = st_out_reg;

        ureq.start = 1'b0;
        ureq.op    = OP_MUL;
        uopa       = '0;
        uopb       = '0;
        in_stall   = (state_reg != S_IDLE);

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    if (m_in == M_ONE_Q28)
                    begin
                        kq_next    = {32{1'b1}};
                        eq_next    = 32'h0100_0000;
                        st_next    = ST_K_INF;
                        state_next = S_FIN;
                    end
                    else if (m_in > M_ONE_Q28)
                    begin
                        kq_next    = '0;
                        eq_next    = '0;
                        st_next    = ST_M_ABOVE;
                        state_next = S_FIN;
                    end
                    else if (!parameter_m[31])
                    begin
                        neg_next   = 1'b0;
                        ureq.start = 1'b1;
                        ureq.op    = OP_SQRT;
                        uopa       = {64'd0, ONE - d_in} << F;
                        s_next     = d_in >> 1;
                        state_next = S_SQRT_B;
                    end
                    else
                    begin
                        // imaginary-modulus transform: m' = -m / (1 - m)
                        neg_next   = 1'b1;
                        w_next     = mneg + 33'(M_ONE_Q28);
                        ureq.start = 1'b1;
                        ureq.op    = OP_DIV;
                        uopa       = {64'd0, 64'(mneg)} << F;
                        uopb       = 64'(mneg + 33'(M_ONE_Q28));
                        state_next = S_DIV_D;
                    end
                end
            end
            S_DIV_D:
            begin
                if (ustat.done)
                begin
                    ureq.start = 1'b1;
                    ureq.op    = OP_SQRT;
                    uopa       = {64'd0, ONE - d_div} << F;
                    s_next     = d_div >> 1;
                    state_next = S_SQRT_B;
                end
            end
            S_SQRT_B:
            begin
                if (ustat.done)
                begin
                    b_next     = ures[63:0];
                    a_next     = ONE;
                    i_next     = '0;
                    state_next = S_STEP;
                end
            end
            S_STEP:
            begin
                c_next     = (a_reg >= b_reg) ? ((a_reg - b_reg) >> 1) : 64'd0;
                t_next     = ab_sum[64:1];
                ureq.start = 1'b1;
                ureq.op    = OP_MUL;
                uopa       = {64'd0, a_reg};
                uopb       = b_reg;
                state_next = S_MUL_AB;
            end
            S_MUL_AB:
            begin
                if (ustat.done)
                begin
                    ureq.start = 1'b1;
                    ureq.op    = OP_SQRT;
                    uopa       = ures;
                    state_next = S_SQRT_AB;
                end
            end
            S_SQRT_AB:
            begin
                if (ustat.done)
                begin
                    b_next     = ures[63:0];
                    a_next     = t_reg;
                    ureq.start = 1'b1;
                    ureq.op    = OP_MUL;
                    uopa       = {64'd0, c_reg};
                    uopb       = c_reg;
                    state_next = S_MUL_CC;
                end
            end
            S_MUL_CC:
            begin
                if (ustat.done)
                begin
                    if (term >= ONE || s_sum > {1'b0, ONE})
                        s_next = ONE;
                    else
                        s_next = s_sum[63:0];
                    if (c_reg == 64'd0)
                    begin
                        ureq.start = 1'b1;
                        ureq.op    = OP_DIV;
                        uopa       = KNUM;
                        uopb       = a_reg;
                        state_next = S_DIV_K;
                    end
                    else if (i_reg == IW'(MAX_ITERATIONS - 1))
                    begin
                        kq_next    = '0;
                        eq_next    = '0;
                        st_next    = ST_NO_CONV;
                        state_next = S_FIN;
                    end
                    else
                    begin
                        i_next     = i_reg + IW'(1);
                        state_next = S_STEP;
                    end
                end
            end
            S_DIV_K:
            begin
                if (ustat.done)
                begin
                    kw_next    = ures[63:0];
                    ureq.start = 1'b1;
                    ureq.op    = OP_MUL;
                    uopa       = {64'd0, ures[63:0]};
                    uopb       = ONE - s_reg;
                    state_next = S_MUL_E;
                end
            end
            S_MUL_E:
            begin
                if (ustat.done)
                begin
                    ew_next = ew_tmp;
                    if (neg_reg)
                    begin
                        // r = sqrt(1 - m) in Q.F
                        ureq.start = 1'b1;
                        ureq.op    = OP_SQRT;
                        uopa       = {95'd0, w_reg} << (2 * F - 28);
                        state_next = S_SQRT_R;
                    end
                    else
                    begin
                        kq_next    = to_q24(kw_reg);
                        eq_next    = to_q24(ew_tmp);
                        st_next    = ST_OK;
                        state_next = S_FIN;
                    end
                end
            end
            S_SQRT_R:
            begin
                if (ustat.done)
                begin
                    r_next     = ures[63:0];
                    ureq.start = 1'b1;
                    ureq.op    = OP_DIV;
                    uopa       = {64'd0, kw_reg} << F;
                    uopb       = ures[63:0];
                    state_next = S_DIV_KN;
                end
            end
            S_DIV_KN:
            begin
                if (ustat.done)
                begin
                    kw_next    = ures[63:0];
                    ureq.start = 1'b1;
                    ureq.op    = OP_MUL;
                    uopa       = {64'd0, ew_reg};
                    uopb       = r_reg;
                    state_next = S_MUL_EN;
                end
            end
            S_MUL_EN:
            begin
                if (ustat.done)
                begin
                    kq_next    = to_q24(kw_reg);
                    eq_next    = to_q24(ew_tmp);
                    st_next    = ST_OK;
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    k_out_next     = kq_reg;
                    e_out_next     = eq_reg;
                    st_out_next    = st_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg    <= neg_next;
        w_reg      <= w_next;
        a_reg      <= a_next;
        b_reg      <= b_next;
        s_reg      <= s_next;
        c_reg      <= c_next;
        t_reg      <= t_next;
        kw_reg     <= kw_next;
        ew_reg     <= ew_next;
        r_reg      <= r_next;
        i_reg      <= i_next;
        kq_reg     <= kq_next;
        eq_reg     <= eq_next;
        st_reg     <= st_next;
        k_out_reg  <= k_out_next;
        e_out_reg  <= e_out_next;
        st_out_reg <= st_out_next;
    end

    assign out_valid = out_valid_reg;
    assign k_value   = k_out_reg;
    assign e_value   = e_out_reg;
    assign status    = st_out_reg;

endmodule

FILE: src/ceagm_unit.sv
`timescale 1ns / 1ps
// Shared arithmetic unit: 64x64 multiply (four 32x32 partials),
// 128/64 restoring divide and 128-bit integer square root, one bit per cycle.
module ceagm_unit (
    input  logic                   clk,
    input  logic                   rst_n,
    input  ceagm_pkg::unit_req_t   req,
    input  logic [127:0]           opa,
    input  logic [63:0]            opb,
    output ceagm_pkg::unit_stat_t  stat,
    output logic [127:0]           res
);
    import ceagm_pkg::*;

    unit_op_t      op_reg, op_next;
    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [5:0]    cnt_reg, cnt_next;
    logic [127:0]  x_reg, x_next;
    logic [63:0]   y_reg, y_next;
    logic [127:0]  acc_reg, acc_next;
    logic [66:0]   rem_reg, rem_next;
    logic [63:0]   q_reg, q_next;

    logic [31:0]   mx, my;
    logic [63:0]   prod;
    logic [1:0]    psh;
    logic [64:0]   dsh;
    logic [66:0]   ssh, trial;

    always_comb
    begin
        mx    = cnt_reg[0] ? x_reg[63:32] : x_reg[31:0];
        my    = cnt_reg[1] ? y_reg[63:32] : y_reg[31:0];
        prod  = mx * my;
        psh   = {cnt_reg[0] & cnt_reg[1], cnt_reg[0] ^ cnt_reg[1]};
        dsh   = {rem_reg[63:0], x_reg[63]};
        ssh   = {rem_reg[64:0], x_reg[127:126]};
        trial = {1'b0, q_reg, 2'b01};

        op_next   = op_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        x_next    = x_reg;
        y_next    = y_reg;
        acc_next  = acc_reg;
        rem_next  = rem_reg;
        q_next    = q_reg;

        if (!busy_reg)
        begin
            if (req.start)
            begin
                op_next   = req.op;
                busy_next = 1'b1;
                cnt_next  = '0;
                x_next    = opa;
                y_next    = opb;
                acc_next  = '0;
                rem_next  = '0;
                q_next    = '0;
                if (req.op == OP_DIV)
                begin
                    rem_next = {3'd0, opa[127:64]};
                    // zero divisor or quotient overflow saturates
                    if (opb == 64'd0 || opa[127:64] >= opb)
                    begin
                        busy_next = 1'b0;
                        done_next = 1'b1;
                        acc_next  = {64'd0, {64{1'b1}}};
                    end
                end
            end
        end
        else
        begin
            cnt_next = cnt_reg + 6'd1;
            unique case (op_reg)
                OP_MUL:
                begin
                    acc_next = acc_reg + ({64'd0, prod} << {psh, 5'd0});
                    if (cnt_reg == 6'd3)
                    begin
                        busy_next = 1'b0;
                        done_next = 1'b1;
                    end
                end
                OP_DIV:
                begin
                    x_next = {x_reg[126:0], 1'b0};
                    if (dsh >= {1'b0, y_reg})
                    begin
                        rem_next = {3'd0, 64'(dsh - {1'b0, y_reg})};
                        q_next   = {q_reg[62:0], 1'b1};
                    end
                    else
                    begin
                        rem_next = {3'd0, dsh[63:0]};
                        q_next   = {q_reg[62:0], 1'b0};
                    end
                    if (cnt_reg == 6'd63)
                    begin
                        busy_next = 1'b0;
                        done_next = 1'b1;
                        acc_next  = {64'd0, q_next};
                    end
                end
                OP_SQRT:
                begin
                    x_next = {x_reg[125:0], 2'b00};
                    if (ssh >= trial)
                    begin
                        rem_next = ssh - trial;
                        q_next   = {q_reg[62:0], 1'b1};
                    end
                    else
                    begin
                        rem_next = ssh;
                        q_next   = {q_reg[62:0], 1'b0};
                    end
                    if (cnt_reg == 6'd63)
                    begin
                        busy_next = 1'b0;
                        done_next = 1'b1;
                        acc_next  = {64'd0, q_next};
                    end
                end
                default:
                begin
                    busy_next = 1'b0;
                    done_next = 1'b1;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_reg   <= OP_MUL;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            op_reg   <= op_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg   <= x_next;
        y_reg   <= y_next;
        acc_reg <= acc_next;
        rem_reg <= rem_next;
        q_reg   <= q_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign res       = acc_reg;

endmodule

FILE: src/ceagm_checker.sv
`timescale 1ns / 1ps
`include "complete_elliptic_integrals_agm_assert.svh"
module ceagm_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_stall,
    input logic [31:0] k_value,
    input logic [31:0] e_value,
    input logic [1:0]  status
);
    import ceagm_pkg::*;

    `CEAGM_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid)
    `CEAGM_ASSERT_NXT(a_out_stable, out_valid && out_stall, $stable(k_value) && $stable(status))
    `CEAGM_ASSERT_IMP(a_k_inf, out_valid && status == ST_K_INF, k_value == 32'hFFFF_FFFF && e_value == 32'h0100_0000)
    `CEAGM_ASSERT_IMP(a_zero_res, out_valid && (status == ST_NO_CONV || status == ST_M_ABOVE), k_value == 32'd0 && e_value == 32'd0)

endmodule

bind complete_elliptic_integrals_agm ceagm_checker u_ceagm_checker (.*);
